/* rtl/aes128_block_cipher_defines.svh */
// Assertion macros shared by the AES-128 block cipher RTL.
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/aes_pkg.sv */
// Types, constants and GF(2^8) functions shared by the AES-128 cipher.
`default_nettype none
package aes_pkg;
    localparam int NUM_ROUNDS = 10;
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef logic [127:0] t_block;

    // Flags that travel with a block along the row of round cells.
    typedef struct packed {
        logic vld;
        logic dec;
    } t_ctl;

    // Multiply by two in GF(2^8) modulo 0x11b.
    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = v[7] ? ((v << 1) ^ 8'h1b) : (v << 1);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ x;
            x = xtime(x);
        end
        gmul = acc;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = v;
        for (int k = 0; k < 8; k++) begin
            if (k != 0) r = gmul(r, b);
            b = gmul(b, b);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        rol8 = (v << n) | (v >> (8 - n));
    endfunction

    // Forward S-box; synthesis folds it to a 256-entry constant table.
    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] b;
        b = ginv(v);
        sbox = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        inv_sbox = ginv(rol8(v, 1) ^ rol8(v, 3) ^ rol8(v, 6) ^ 8'h05);
    endfunction

    function automatic logic [31:0] word_subst(input logic [31:0] w);
        word_subst = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Next AES-128 round key from the previous one.
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        t  = word_subst({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] st_byte(input t_block s, input int i);
        st_byte = s[127 - 8 * i -: 8];
    endfunction
endpackage
`default_nettype wire

/* rtl/aes_key_cell.sv */
// One cell of the key schedule row: holds a round key and derives the next.
`default_nettype none
module aes_key_cell
    import aes_pkg::*;
#(
    parameter logic [7:0] RCON = 8'h01
) (
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire t_block i_key,
    output t_block      o_key
);
    t_block r_key;

    // Each cell registers the next round key whenever i_en is high, so a new key
    // ripples down the row one cell per cycle while the cells are enabled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= next_key(i_key, RCON);
        end
    end

    assign o_key = r_key;
endmodule
`default_nettype wire

/* rtl/aes_round_cell.sv */
// One round cell: an encrypt or decrypt AES round on the passing block.
`default_nettype none
module aes_round_cell
    import aes_pkg::*;
#(
    parameter bit LAST = 1'b0
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_ctl   i_ctl,
    input  wire t_block i_state,
    input  wire t_block i_enc_key,
    input  wire t_block i_dec_key,
    output t_ctl        o_ctl,
    output t_block      o_state
);
    t_ctl   r_ctl;
    t_block r_state;
    t_block n_state;

    always_comb begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        t_block     v;
        // Encrypt: sub, shift, mix (not in the last cell), add key.
        // Decrypt: inverse shift, inverse sub, add key, inverse mix (not in the last cell).
        for (int i = 0; i < 16; i++) s[i] = st_byte(i_state, i);
        for (int i = 0; i < 16; i++) begin
            if (i_ctl.dec == CMD_DEC) begin
                t[i] = inv_sbox(s[4 * (((i / 4) + 4 - (i % 4)) % 4) + (i % 4)]);
            end else begin
                t[i] = sbox(s[4 * (((i / 4) + (i % 4)) % 4) + (i % 4)]);
            end
        end
        if (i_ctl.dec == CMD_DEC) begin
            for (int i = 0; i < 16; i++) t[i] = t[i] ^ st_byte(i_dec_key, i);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = t[4 * c + r];
            for (int r = 0; r < 4; r++) begin
                if (LAST) begin
                    v[127 - 8 * (4 * c + r) -: 8] = a[r];
                end else if (i_ctl.dec == CMD_DEC) begin
                    v[127 - 8 * (4 * c + r) -: 8] = gmul(a[r], 8'h0e)
                        ^ gmul(a[(r + 1) % 4], 8'h0b) ^ gmul(a[(r + 2) % 4], 8'h0d)
                        ^ gmul(a[(r + 3) % 4], 8'h09);
                end else begin
                    v[127 - 8 * (4 * c + r) -: 8] = xtime(a[r])
                        ^ xtime(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
                        ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
                end
            end
        end
        n_state = (i_ctl.dec == CMD_DEC) ? v : (v ^ i_enc_key);
    end

    // Cell registers move whenever the row is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;
endmodule
`default_nettype wire

/* rtl/aes128_block_cipher.sv */
// Top level of the pipelined AES-128 ECB encrypt and decrypt engine.
// One block enters per cycle while the input is ready. An input stage adds the first
// round key (the last round key for decryption), then ten round cells, each a register
// stage, carry the block to the output. The key schedule is a row of ten key cells that
// takes a new key one cell further per cycle; after reset or after any key register
// write the input is held not ready while the row settles, so every block accepted
// afterwards uses the new key. While the output is stalled the input stage and the
// round cells hold; the key row does not.
`default_nettype none
`include "aes128_block_cipher_defines.svh"
module aes128_block_cipher
    import aes_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // block_low, block_high
    input  wire logic         s_axis_tuser,  // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata   // result_low, result_high
);
    localparam logic [3:0] KEY_SETTLE = 4'(NUM_ROUNDS);

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic [3:0]  r_settle;
    t_block      w_key [NUM_ROUNDS + 1];
    t_ctl        w_ctl [NUM_ROUNDS + 1];
    t_block      w_st  [NUM_ROUNDS + 1];
    t_ctl        r_ctl0;
    t_block      r_st0;
    logic        w_en;
    t_ctl        w_in_ctl;
    t_block      w_blk;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Settling count: the input waits while a new key ripples down the key row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= KEY_SETTLE;
        end else if (i_cfg_we) begin
            r_settle <= KEY_SETTLE;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 4'd1;
        end
    end

    assign w_key[0] = {r_key_high, r_key_low};

    // Key schedule row.
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_key
        localparam logic [7:0] RC = (g < 8) ? (8'h01 << g) : ((g == 8) ? 8'h1b : 8'h36);
        aes_key_cell #(.RCON(RC)) u_key (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_key (w_key[g]),
            .o_key (w_key[g + 1])
        );
    end

    // Row advances unless a result waits at the output.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en && (r_settle == '0);
    assign w_blk         = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign w_in_ctl      = '{vld: s_axis_tvalid && s_axis_tready, dec: s_axis_tuser};

    // Input stage: initial key addition.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_en) begin
            r_ctl0 <= w_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st0 <= w_blk ^ ((s_axis_tuser == CMD_DEC) ? w_key[NUM_ROUNDS] : w_key[0]);
        end
    end

    assign w_ctl[0] = r_ctl0;
    assign w_st[0]  = r_st0;

    // Round cell row.
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_rnd
        aes_round_cell #(.LAST(g == NUM_ROUNDS - 1)) u_rnd (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_ctl     (w_ctl[g]),
            .i_state   (w_st[g]),
            .i_enc_key (w_key[g + 1]),
            .i_dec_key (w_key[NUM_ROUNDS - 1 - g]),
            .o_ctl     (w_ctl[g + 1]),
            .o_state   (w_st[g + 1])
        );
    end

    assign m_axis_tvalid = w_ctl[NUM_ROUNDS].vld;
    assign m_axis_tdata  = {w_st[NUM_ROUNDS][63:0], w_st[NUM_ROUNDS][127:64]};

    `AES_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
    `AES_ASSERT(a_ready, i_clk, i_rst_n, !m_axis_tvalid && r_settle == '0 |-> s_axis_tready, "input blocked")
    `AES_ASSERT(a_settle, i_clk, i_rst_n, i_cfg_we |=> !s_axis_tready, "input open during key settle")
    `AES_ASSERT_RST(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule
`default_nettype wire
